FILE: rtl/char_lcd_nibble_write_sequencer_macros.svh
// Assertion macros used by the character LCD job queue RTL.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CLCD_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/clcd_pkg.sv
// Shared types and constants for the character LCD nibble write sequencer.
`default_nettype none
package clcd_pkg;

  typedef enum logic [1:0] {
    JOB_RAW    = 2'd0,
    JOB_NIBBLE = 2'd1,
    JOB_BYTE   = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    AFTER_0    = 2'd0,
    AFTER_45   = 2'd1,
    AFTER_2000 = 2'd2
  } after_t;

  // One unit of bus work handed from the front to the back.
  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] data;
    after_t     after;
    logic       last;
  } job_t;

  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_COMMAND = 3'd1;
  localparam logic [2:0] OP_CHAR    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_CURSOR  = 3'd4;
  localparam logic [2:0] OP_PRINT   = 3'd5;

  localparam logic [7:0] CMD_FUNCTION_SET = 8'b0010_1000;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'b0000_1100;
  localparam logic [7:0] CMD_CLEAR        = 8'b0000_0001;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'b0000_0110;
  localparam logic [3:0] WAKE_NIBBLE      = 4'b0010;
  localparam logic [7:0] LINE0_BASE       = 8'h80;
  localparam logic [7:0] LINE1_BASE       = 8'hC0;
  localparam logic [7:0] MAX_COLUMN       = 8'd15;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  localparam logic [15:0] PULSE_US    = 16'd1000;
  localparam logic [15:0] POWER_UP_US = 16'd35000;

  function automatic logic [15:0] after_us(input after_t a);
    logic [15:0] us;
    case (a)
      AFTER_45:   us = 16'd45;
      AFTER_2000: us = 16'd2000;
      default:    us = 16'd0;
    endcase
    return us;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/clcd_front.sv
// Request decoder: turns each request into bus jobs, converts numbers to BCD.
`default_nettype none
module clcd_front import clcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [7:0]  byte_value,
  input  logic        line,
  input  logic [7:0]  position,
  input  logic [31:0] number,
  output logic        job_push,
  output job_t        job,
  input  logic        job_full
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIXED = 4'b0010,
    ST_CONV  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  localparam logic [2:0] INIT_LAST_STEP = 3'd5;
  localparam logic [4:0] CONV_LAST_BIT  = 5'd31;
  localparam logic [3:0] NUM_DIGITS     = 4'd10;

  state_t      state;
  logic [2:0]  op;
  logic [7:0]  byte_reg;
  logic        line_reg;
  logic [3:0]  col;
  logic [2:0]  step;
  logic [31:0] bin;
  logic [39:0] bcd;
  logic [4:0]  bit_cnt;
  logic [3:0]  digits_left;
  logic        started;

  logic        skip;
  logic        fixed_last;
  logic [39:0] bcd_adj;

  // add-3 correction on every BCD digit ahead of the shift
  function automatic logic [39:0] dabble(input logic [39:0] v);
    logic [39:0] r;
    r = v;
    for (int i = 0; i < 10; i++) begin
      if (v[i*4 +: 4] > 4'd4) r[i*4 +: 4] = v[i*4 +: 4] + 4'd3;
    end
    return r;
  endfunction

  assign bcd_adj    = dabble(bcd);
  assign full       = (state != ST_IDLE);
  assign skip       = !started && (bcd[39:36] == 4'd0) && (digits_left != 4'd1);
  assign fixed_last = (op != OP_INIT) || (step == INIT_LAST_STEP);
  assign job_push   = !job_full && ((state == ST_FIXED) || (state == ST_DIGIT && !skip));

  always_comb begin
    job = '{kind: JOB_BYTE, rs: 1'b0, data: 8'h00, after: AFTER_0, last: 1'b0};
    if (state == ST_DIGIT) begin
      job.rs   = 1'b1;
      job.data = ASCII_ZERO | {4'h0, bcd[39:36]};
      job.last = (digits_left == 4'd1);
    end else begin
      case (op)
        OP_INIT: begin
          case (step)
            3'd0: job.kind = JOB_RAW;
            3'd1: begin
              job.kind = JOB_NIBBLE;
              job.data = {4'h0, WAKE_NIBBLE};
            end
            3'd2: begin
              job.data  = CMD_FUNCTION_SET;
              job.after = AFTER_45;
            end
            3'd3: begin
              job.data  = CMD_DISPLAY_ON;
              job.after = AFTER_45;
            end
            3'd4: begin
              job.data  = CMD_CLEAR;
              job.after = AFTER_2000;
            end
            default: begin
              job.data = CMD_ENTRY_MODE;
              job.last = 1'b1;
            end
          endcase
        end
        OP_CHAR: begin
          job.rs   = 1'b1;
          job.data = byte_reg;
          job.last = 1'b1;
        end
        OP_CLEAR: begin
          job.data  = CMD_CLEAR;
          job.after = AFTER_2000;
          job.last  = 1'b1;
        end
        OP_CURSOR: begin
          job.data = (line_reg ? LINE1_BASE : LINE0_BASE) | {4'h0, col};
          job.last = 1'b1;
        end
        default: begin
          job.data = byte_reg;
          job.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            op       <= opcode;
            byte_reg <= byte_value;
            line_reg <= line;
            col      <= position[3:0];
            step     <= 3'd0;
            unique case (opcode) inside
              OP_INIT, OP_COMMAND, OP_CHAR, OP_CLEAR: state <= ST_FIXED;
              OP_CURSOR: begin
                if (position <= MAX_COLUMN) state <= ST_FIXED;
              end
              OP_PRINT: begin
                bin     <= number;
                bcd     <= '0;
                bit_cnt <= 5'd0;
                state   <= ST_CONV;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_FIXED: begin
          if (!job_full) begin
            step <= step + 3'd1;
            if (fixed_last) state <= ST_IDLE;
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[38:0], bin[31]};
          bin     <= {bin[30:0], 1'b0};
          bit_cnt <= bit_cnt + 5'd1;
          if (bit_cnt == CONV_LAST_BIT) begin
            digits_left <= NUM_DIGITS;
            started     <= 1'b0;
            state       <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (skip) begin
            bcd         <= {bcd[35:0], 4'h0};
            digits_left <= digits_left - 4'd1;
          end else if (!job_full) begin
            bcd         <= {bcd[35:0], 4'h0};
            digits_left <= digits_left - 4'd1;
            started     <= 1'b1;
            if (digits_left == 4'd1) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/clcd_job_fifo.sv
// Short job queue between the request decoder and the bus sequencer.
`default_nettype none
`include "char_lcd_nibble_write_sequencer_macros.svh"
module clcd_job_fifo import clcd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  `CLCD_ASSERT(a_count_bound, count <= FULL_CNT, "job queue count beyond depth")
  `CLCD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + CW'(1), "queue push lost")
  `CLCD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count == $past(count) - CW'(1), "queue pop lost")

endmodule
`default_nettype wire

FILE: rtl/clcd_back.sv
// Bus sequencer: expands each job into pin-state items behind an output register.
`default_nettype none
module clcd_back import clcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_empty,
  input  job_t        job,
  output logic        job_pop,
  output logic        empty,
  input  logic        pop,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable,
  output logic [3:0]  data_nibble,
  output logic [15:0] wait_us,
  output logic        last
);

  job_t        cur;
  logic        job_valid;
  logic [1:0]  idx;
  logic        out_valid;

  logic        out_free;
  logic        item_en;
  logic        item_final;
  logic [3:0]  item_nib;
  logic [15:0] item_wait;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign job_pop  = !job_valid && !job_empty;

  always_comb begin
    // for nibble and byte jobs even steps raise E, odd steps drop it; a byte sends its high nibble first
    item_en  = (cur.kind != JOB_RAW) && !idx[0];
    item_nib = (cur.kind == JOB_BYTE && !idx[1]) ? cur.data[7:4] : cur.data[3:0];
    case (cur.kind)
      JOB_RAW:    item_final = 1'b1;
      JOB_NIBBLE: item_final = (idx == 2'd1);
      JOB_BYTE:   item_final = (idx == 2'd3);
      default:    item_final = 1'b1;
    endcase
    if (item_en)                  item_wait = PULSE_US;
    else if (cur.kind == JOB_RAW) item_wait = POWER_UP_US;
    else if (item_final)          item_wait = after_us(cur.after);
    else                          item_wait = 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        cur       <= job;
        idx       <= 2'd0;
        job_valid <= 1'b1;
      end else if (job_valid && out_free) begin
        idx <= idx + 2'd1;
        if (item_final) job_valid <= 1'b0;
      end
      if (job_valid && out_free) begin
        out_valid   <= 1'b1;
        reg_select  <= cur.rs;
        read_write  <= 1'b0;
        enable      <= item_en;
        data_nibble <= item_nib;
        wait_us     <= item_wait;
        last        <= cur.last && item_final;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// Top level of the 4-bit character LCD write sequencer.
// Each request (init, command, character, clear, set cursor, print number) becomes a run
// of pin-state items for a 4-bit HD44780-style bus: RS, RW, E, D7..D4 and a hold time
// in microseconds; last marks the final item of a request. Every byte is two nibbles,
// high first, each as an E-high item held 1000 us and an E-low item. The decoder is busy
// (full high) while it queues the jobs of a request and stalls while the job queue is full;
// print number also first runs a binary-to-BCD conversion and then skips leading zero
// digits. The bus sequencer emits one item per cycle while the sink keeps pop high,
// pausing to fetch each job from the queue. The job queue (JOB_FIFO_DEPTH entries) lets
// the decoder take the next request while the sequencer is still draining earlier ones.
// Set cursor with a column above 15 and unused opcodes produce no items.
`default_nettype none
module char_lcd_nibble_write_sequencer import clcd_pkg::*; #(
  parameter int JOB_FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  opcode,
  input  logic [7:0]  byte_value,
  input  logic        line,
  input  logic [7:0]  position,
  input  logic [31:0] number,
  output logic        empty,
  input  logic        pop,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable,
  output logic [3:0]  data_nibble,
  output logic [15:0] wait_us,
  output logic        last
);

  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  job_t job_in;
  job_t job_out;

  clcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .byte_value (byte_value),
    .line       (line),
    .position   (position),
    .number     (number),
    .job_push   (job_push),
    .job        (job_in),
    .job_full   (job_full)
  );

  clcd_job_fifo #(
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_out)
  );

  clcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_empty   (job_empty),
    .job         (job_out),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .reg_select  (reg_select),
    .read_write  (read_write),
    .enable      (enable),
    .data_nibble (data_nibble),
    .wait_us     (wait_us),
    .last        (last)
  );

endmodule
`default_nettype wire

FILE: verif/tb_char_lcd_nibble_write_sequencer.sv
// Self-checking testbench for the 4-bit character LCD write sequencer.
`timescale 1ns / 1ps
module tb_char_lcd_nibble_write_sequencer import clcd_pkg::*;;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int POP_ALWAYS = 0;
  localparam int POP_COIN   = 1;
  localparam int POP_MASK   = 2;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } pin_state_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  opcode;
  logic [7:0]  byte_value;
  logic        line;
  logic [7:0]  position;
  logic [31:0] number;
  logic        empty;
  logic        pop;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [3:0]  data_nibble;
  logic [15:0] wait_us;
  logic        last;

  pin_state_t  expected_pins[$];
  int unsigned mismatches = 0;
  int          burst_left = 0;
  int          max_gap = 6;
  int          hold_off_cycles = 0;

  char_lcd_nibble_write_sequencer u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .byte_value  (byte_value),
    .line        (line),
    .position    (position),
    .number      (number),
    .empty       (empty),
    .pop         (pop),
    .reg_select  (reg_select),
    .read_write  (read_write),
    .enable      (enable),
    .data_nibble (data_nibble),
    .wait_us     (wait_us),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- expected pin sequence ----------------

  task automatic queue_pin(input logic rs, input logic en, input logic [3:0] nib,
                           input logic [15:0] hold);
    pin_state_t p;
    p.rs   = rs;
    p.rw   = 1'b0;
    p.en   = en;
    p.nib  = nib;
    p.hold = hold;
    p.last = 1'b0;
    expected_pins.push_back(p);
  endtask

  // E high for the pulse width, then E low held for the trailing delay
  task automatic queue_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] after);
    queue_pin(rs, 1'b1, nib, PULSE_US);
    queue_pin(rs, 1'b0, nib, after);
  endtask

  task automatic queue_byte(input logic rs, input logic [7:0] b, input logic [15:0] after);
    queue_nibble(rs, b[7:4], 16'd0);
    queue_nibble(rs, b[3:0], after);
  endtask

  task automatic predict_pins(input logic [2:0] op, input logic [7:0] bv, input logic ln,
                              input logic [7:0] pos, input logic [31:0] num);
    int         start;
    int         n;
    logic [3:0] digits [10];
    logic [31:0] rest;
    pin_state_t p;
    start = expected_pins.size();
    case (op)
      OP_INIT: begin
        queue_pin(1'b0, 1'b0, 4'h0, POWER_UP_US);
        queue_nibble(1'b0, WAKE_NIBBLE, 16'd0);
        queue_byte(1'b0, CMD_FUNCTION_SET, 16'd45);
        queue_byte(1'b0, CMD_DISPLAY_ON, 16'd45);
        queue_byte(1'b0, CMD_CLEAR, 16'd2000);
        queue_byte(1'b0, CMD_ENTRY_MODE, 16'd0);
      end
      OP_COMMAND: queue_byte(1'b0, bv, 16'd0);
      OP_CHAR:    queue_byte(1'b1, bv, 16'd0);
      OP_CLEAR:   queue_byte(1'b0, CMD_CLEAR, 16'd2000);
      OP_CURSOR: begin
        if (pos <= MAX_COLUMN)
          queue_byte(1'b0, (ln ? LINE1_BASE : LINE0_BASE) + pos, 16'd0);
      end
      OP_PRINT: begin
        rest = num;
        n = 0;
        do begin
          digits[n] = 4'(rest % 10);
          rest = rest / 10;
          n++;
        end while (rest != 0);
        while (n > 0) begin
          n--;
          queue_byte(1'b1, ASCII_ZERO + 8'(digits[n]), 16'd0);
        end
      end
      default: ;
    endcase
    if (expected_pins.size() > start) begin
      p = expected_pins.pop_back();
      p.last = 1'b1;
      expected_pins.push_back(p);
    end
  endtask

  // ---------------- request side ----------------

  task automatic send_request(input logic [2:0] op, input logic [7:0] bv, input logic ln,
                              input logic [7:0] pos, input logic [31:0] num);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push       <= 1'b1;
    opcode     <= op;
    byte_value <= bv;
    line       <= ln;
    position   <= pos;
    number     <= num;
    do @(posedge clk); while (full);
    predict_pins(op, bv, ln, pos, num);
  endtask

  // ---------------- result side: check, then choose next pop ----------------

  task automatic report_mismatch(input string what, input pin_state_t want,
                                 input pin_state_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $write("%0t mismatch (%s): exp rs=%0d rw=%0d e=%0d d=%h us=%0d last=%0d, ",
             $realtime, what, want.rs, want.rw, want.en, want.nib, want.hold, want.last);
      $display("got rs=%0d rw=%0d e=%0d d=%h us=%0d last=%0d",
               got.rs, got.rw, got.en, got.nib, got.hold, got.last);
    end
  endtask

  initial begin
    int         pop_mode;
    int         mode_left;
    logic [7:0] pop_mask;
    pin_state_t got;
    pin_state_t want;
    pop_mode  = POP_ALWAYS;
    mode_left = 0;
    pop_mask  = 8'h01;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{reg_select, read_write, enable, data_nibble, wait_us, last};
        if (expected_pins.size() == 0) begin
          report_mismatch("unexpected", '0, got);
        end else begin
          want = expected_pins.pop_front();
          if (got.rs !== want.rs)          report_mismatch("reg_select", want, got);
          else if (got.rw !== want.rw)     report_mismatch("read_write", want, got);
          else if (got.en !== want.en)     report_mismatch("enable", want, got);
          else if (got.nib !== want.nib)   report_mismatch("data_nibble", want, got);
          else if (got.hold !== want.hold) report_mismatch("wait_us", want, got);
          else if (got.last !== want.last) report_mismatch("last", want, got);
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          pop_mode  = $urandom_range(POP_ALWAYS, POP_MASK);
          mode_left = $urandom_range(20, 80);
          pop_mask  = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (pop_mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_COIN:   pop <= 1'($urandom_range(0, 1));
          default: begin
            pop <= pop_mask[0];
            pop_mask = {pop_mask[0], pop_mask[7:1]};
          end
        endcase
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_init();
    send_request(OP_INIT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), $urandom);
  endtask

  task automatic test_bytes();
    send_request(OP_COMMAND, 8'h00, 1'b0, 8'h00, 32'h0);
    send_request(OP_COMMAND, 8'hFF, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_CHAR, 8'h00, 1'b1, 8'hFF, 32'h0);
    send_request(OP_CHAR, 8'hFF, 1'b0, 8'h00, 32'hFFFF_FFFF);
    send_request(OP_CHAR, 8'hA5, 1'b0, 8'h5A, 32'h1234_5678);
    send_request(OP_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), $urandom);
  endtask

  // column above fifteen yields nothing
  task automatic test_cursor();
    send_request(OP_CURSOR, 8'($urandom), 1'b0, 8'd0, $urandom);
    send_request(OP_CURSOR, 8'($urandom), 1'b1, 8'd15, $urandom);
    send_request(OP_CURSOR, 8'($urandom), 1'b0, 8'd15, $urandom);
    send_request(OP_CURSOR, 8'($urandom), 1'b1, 8'd0, $urandom);
    send_request(OP_CURSOR, 8'($urandom), 1'b0, 8'd16, $urandom);
    send_request(OP_CURSOR, 8'($urandom), 1'b1, 8'd255, $urandom);
  endtask

  task automatic test_print();
    send_request(OP_PRINT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), 32'd0);
    send_request(OP_PRINT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), 32'd9);
    send_request(OP_PRINT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), 32'd10);
    send_request(OP_PRINT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                 32'd1_000_000_000);
    send_request(OP_PRINT, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom),
                 32'hFFFF_FFFF);
  endtask

  task automatic test_spare_opcodes();
    send_request(OP_SPARE_6, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), $urandom);
    send_request(OP_SPARE_7, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom), $urandom);
    send_request(OP_CHAR, 8'h41, 1'b0, 8'h00, 32'h0);
  endtask

  task automatic random_request(output logic silent);
    int unsigned pick;
    int          n_digits;
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] num;
    pick = $urandom_range(0, 99);
    if (pick < 8)       op = OP_INIT;
    else if (pick < 25) op = OP_COMMAND;
    else if (pick < 45) op = OP_CHAR;
    else if (pick < 52) op = OP_CLEAR;
    else if (pick < 70) op = OP_CURSOR;
    else if (pick < 95) op = OP_PRINT;
    else                op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
    pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(16, 255)) : 8'($urandom_range(0, 15));
    n_digits = $urandom_range(1, 10);
    num = $urandom_range(0, 9);
    repeat (n_digits - 1) num = num * 10 + $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) num = $urandom;
    send_request(op, 8'($urandom), 1'($urandom_range(0, 1)), pos, num);
    silent = (op == OP_SPARE_6) || (op == OP_SPARE_7) || (op == OP_CURSOR && pos > MAX_COLUMN);
  endtask

  task automatic test_random_requests(input int unsigned count);
    int unsigned done;
    logic        silent;
    done = 0;
    while (done < count) begin
      random_request(silent);
      if (!silent) done++;
    end
  endtask

  // sink holds off while requests keep coming back to back
  task automatic test_backpressure();
    logic silent;
    max_gap = 0;
    hold_off_cycles = 500;
    repeat (16) random_request(silent);
    max_gap = 6;
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    opcode     = OP_INIT;
    byte_value = 8'h00;
    line       = 1'b0;
    position   = 8'h00;
    number     = 32'h0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_init();
    test_bytes();
    test_cursor();
    test_print();
    test_spare_opcodes();
    test_backpressure();
    test_random_requests(70);

    push <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
